@@ rtl/fcwg_pkg.sv @@
// fcwg_pkg: types, constants and table functions shared by the waveform generator
// used by fcwg_front, fcwg_queue, fcwg_back and the top level
`timescale 1ns / 1ps

package fcwg_pkg;

   localparam int TABLE_POINTS = 128;
   localparam int IDX_W        = $clog2(TABLE_POINTS);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_W        = 32;
   localparam int DIVISOR_W    = 22;
   localparam int STEP_W       = $clog2(DIV_W);

   localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
   localparam logic [15:0] DAC_CMD     = 16'hC000;
   localparam logic [31:0] F_MIN       = 32'd1;
   localparam logic [31:0] F_MAX       = 32'd20000;
   localparam logic [7:0]  PRESET_LAST = 8'd13;
   localparam logic [7:0]  WAVES       = 8'd5;
   localparam logic [7:0]  AMP_RESET   = 8'd127;
   localparam logic [2:0]  LAST_BYTE   = 3'd4;

   localparam logic [3:0] FN_WAVE   = 4'd0;
   localparam logic [3:0] FN_FREQ   = 4'd1;
   localparam logic [3:0] FN_AMP    = 4'd2;
   localparam logic [3:0] FN_SYNC   = 4'd3;
   localparam logic [3:0] FN_PRESET = 4'd4;

   localparam logic [2:0] WAVE_SIN = 3'd0;
   localparam logic [2:0] WAVE_SQR = 3'd1;
   localparam logic [2:0] WAVE_TRI = 3'd2;
   localparam logic [2:0] WAVE_SAW = 3'd3;
   localparam logic [2:0] WAVE_ARB = 3'd4;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_WAVE,
      OP_FREQ,
      OP_AMP,
      OP_SYNC
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam logic [7:0] SINE_PTS [TABLE_POINTS] = '{
      8'd64,8'd67,8'd70,8'd73,8'd76,8'd79,8'd82,8'd85,
      8'd88,8'd91,8'd93,8'd96,8'd99,8'd101,8'd104,8'd106,
      8'd108,8'd111,8'd113,8'd115,8'd116,8'd118,8'd120,8'd121,
      8'd122,8'd123,8'd124,8'd125,8'd126,8'd126,8'd127,8'd127,
      8'd127,8'd127,8'd127,8'd126,8'd126,8'd125,8'd124,8'd123,
      8'd122,8'd121,8'd120,8'd118,8'd116,8'd115,8'd113,8'd111,
      8'd108,8'd106,8'd104,8'd101,8'd99,8'd96,8'd93,8'd91,
      8'd88,8'd85,8'd82,8'd79,8'd76,8'd73,8'd70,8'd67,
      8'd64,8'd60,8'd57,8'd54,8'd51,8'd48,8'd45,8'd42,
      8'd39,8'd36,8'd34,8'd31,8'd28,8'd26,8'd23,8'd21,
      8'd19,8'd16,8'd14,8'd12,8'd11,8'd9,8'd7,8'd6,
      8'd5,8'd4,8'd3,8'd2,8'd1,8'd1,8'd0,8'd0,
      8'd0,8'd0,8'd0,8'd1,8'd1,8'd2,8'd3,8'd4,
      8'd5,8'd6,8'd7,8'd9,8'd11,8'd12,8'd14,8'd16,
      8'd19,8'd21,8'd23,8'd26,8'd28,8'd31,8'd34,8'd36,
      8'd39,8'd42,8'd45,8'd48,8'd51,8'd54,8'd57,8'd60
   };

   localparam logic [7:0] TRI_PTS [TABLE_POINTS] = '{
      8'd0,8'd2,8'd4,8'd6,8'd8,8'd10,8'd12,8'd14,
      8'd16,8'd18,8'd20,8'd22,8'd24,8'd26,8'd28,8'd30,
      8'd32,8'd34,8'd36,8'd38,8'd40,8'd42,8'd44,8'd46,
      8'd48,8'd50,8'd52,8'd54,8'd56,8'd58,8'd60,8'd62,
      8'd64,8'd65,8'd67,8'd69,8'd71,8'd73,8'd75,8'd77,
      8'd79,8'd81,8'd83,8'd85,8'd87,8'd89,8'd91,8'd93,
      8'd95,8'd97,8'd99,8'd101,8'd103,8'd105,8'd107,8'd109,
      8'd111,8'd113,8'd115,8'd117,8'd119,8'd121,8'd123,8'd125,
      8'd127,8'd125,8'd123,8'd121,8'd119,8'd117,8'd115,8'd113,
      8'd111,8'd109,8'd107,8'd105,8'd103,8'd101,8'd99,8'd97,
      8'd95,8'd93,8'd91,8'd89,8'd87,8'd85,8'd83,8'd81,
      8'd79,8'd77,8'd75,8'd73,8'd71,8'd69,8'd67,8'd65,
      8'd64,8'd62,8'd60,8'd58,8'd56,8'd54,8'd52,8'd50,
      8'd48,8'd46,8'd44,8'd42,8'd40,8'd38,8'd36,8'd34,
      8'd32,8'd30,8'd28,8'd26,8'd24,8'd22,8'd20,8'd18,
      8'd16,8'd14,8'd12,8'd10,8'd8,8'd6,8'd4,8'd2
   };

   function automatic logic [31:0] preset_hz(input logic [3:0] sel);
      logic [31:0] f;
      case (sel)
         4'd0:    f = 32'd1;
         4'd1:    f = 32'd2;
         4'd2:    f = 32'd5;
         4'd3:    f = 32'd10;
         4'd4:    f = 32'd20;
         4'd5:    f = 32'd50;
         4'd6:    f = 32'd100;
         4'd7:    f = 32'd200;
         4'd8:    f = 32'd500;
         4'd9:    f = 32'd1000;
         4'd10:   f = 32'd2000;
         4'd11:   f = 32'd5000;
         4'd12:   f = 32'd10000;
         4'd13:   f = 32'd20000;
         default: f = 32'd1;
      endcase
      return f;
   endfunction

   function automatic logic [7:0] wave_point(input logic [2:0] wave,
                                             input logic [IDX_W-1:0] idx);
      logic [7:0] p;
      case (wave)
         WAVE_SIN: p = SINE_PTS[idx];
         WAVE_SQR: p = idx[IDX_W-1] ? 8'd0 : 8'd127;
         WAVE_TRI: p = TRI_PTS[idx];
         WAVE_SAW: p = 8'(idx);
         WAVE_ARB: p = SINE_PTS[idx];
         default:  p = SINE_PTS[idx];
      endcase
      return p;
   endfunction

endpackage

@@ rtl/fcwg_front.sv @@
// fcwg_front: accepts request words, finds frames and turns them into commands
// depends on fcwg_pkg; feeds fcwg_queue
`timescale 1ns / 1ps

module fcwg_front
   import fcwg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_func,
   input  logic [7:0]   req_rx_byte,
   input  logic         req_rx_error,
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      push_cmd
);

   logic       found_ff, found_in;
   logic [2:0] count_ff, count_in;
   logic [7:0] frame_ff [4];
   logic       frame_we;
   logic       accept;
   logic [3:0] fn;
   logic [7:0] d0;

   assign req_stall = q_status.full;
   assign accept    = req_valid & ~q_status.full;
   assign fn        = frame_ff[0][7:4];
   assign d0        = frame_ff[1];

   always_comb begin
      found_in      = found_ff;
      count_in      = count_ff;
      frame_we      = 1'b0;
      push          = 1'b0;
      push_cmd.op   = OP_TICK;
      push_cmd.data = 32'd0;
      if (accept) begin
         if (req_func) begin
            push = 1'b1;
         end else if (req_rx_error) begin
            found_in = 1'b0;
            count_in = 3'd0;
         end else if (!found_ff) begin
            if (req_rx_byte == SYNC_BYTE) begin
               found_in = 1'b1;
               count_in = 3'd0;
            end
         end else if (count_ff != LAST_BYTE) begin
            frame_we = 1'b1;
            count_in = count_ff + 3'd1;
         end else begin
            found_in = 1'b0;
            count_in = 3'd0;
            case (fn)
               FN_WAVE: begin
                  push          = (d0 < WAVES);
                  push_cmd.op   = OP_WAVE;
                  push_cmd.data = {24'd0, d0};
               end
               FN_FREQ: begin
                  push          = 1'b1;
                  push_cmd.op   = OP_FREQ;
                  push_cmd.data = {req_rx_byte, frame_ff[3], frame_ff[2], frame_ff[1]};
               end
               FN_AMP: begin
                  push          = 1'b1;
                  push_cmd.op   = OP_AMP;
                  push_cmd.data = {24'd0, d0};
               end
               FN_SYNC: begin
                  push          = 1'b1;
                  push_cmd.op   = OP_SYNC;
                  push_cmd.data = {24'd0, d0};
               end
               FN_PRESET: begin
                  push          = (d0 <= PRESET_LAST);
                  push_cmd.op   = OP_FREQ;
                  push_cmd.data = preset_hz(d0[3:0]);
               end
               default: begin
                  push = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         count_ff <= 3'd0;
      end else begin
         found_ff <= found_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_ff[count_ff[1:0]] <= req_rx_byte;
      end
   end

   // parser only counts while a frame is open
   a_count_idle : assert property (@(posedge clock) disable iff (reset)
      !found_ff |-> count_ff == 3'd0)
      else $error("byte count moved outside a frame");

   a_count_max : assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_BYTE)
      else $error("byte count past last data byte");

endmodule

@@ rtl/fcwg_queue.sv @@
// fcwg_queue: short command queue between the parser and the executor
// depends on fcwg_pkg
`timescale 1ns / 1ps

module fcwg_queue
   import fcwg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head_cmd,
   output q_status_type q_status
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push & ~q_status.full;
   assign do_pop         = pop & ~q_status.empty;
   assign head_cmd       = slot_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("command dropped on full queue");

   a_ptr_gap : assert property (@(posedge clock) disable iff (reset)
      (count_ff != QCNT_W'(QUEUE_DEPTH) && count_ff != '0) |-> wr_ff != rd_ff)
      else $error("queue pointers disagree with fill count");

endmodule

@@ rtl/fcwg_back.sv @@
// fcwg_back: executes commands, runs the reload divider and builds dac words
// depends on fcwg_pkg; pops fcwg_queue
`timescale 1ns / 1ps

module fcwg_back
   import fcwg_pkg::*;
#(
   parameter int unsigned CLOCK_HZ = 100000000
)
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      head_cmd,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [15:0]  rsp_dac_word,
   output logic         rsp_reload_valid,
   output logic [31:0]  rsp_reload_value,
   output logic         rsp_sync_enable
);

   localparam logic [DIV_W-1:0] CLOCK_WORD = DIV_W'(CLOCK_HZ);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DIV  = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [2:0]           wave_ff, wave_in;
   logic [7:0]           amp_ff, amp_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [31:0]          pend_val_ff, pend_val_in;
   logic                 sync_ff, sync_in;
   logic                 out_valid_ff, out_valid_in;
   logic [15:0]          dac_ff, dac_in;
   logic                 rv_ff, rv_in;
   logic [31:0]          rval_ff, rval_in;
   logic                 rsync_ff, rsync_in;

   logic                 out_free;
   logic                 is_tick;
   logic [31:0]          f_clamped;
   logic [DIVISOR_W:0]   trial;
   logic                 ge;
   logic [DIV_W-1:0]     q_final;
   logic [DIV_W-1:0]     cnt;
   logic [7:0]           raw;
   logic [15:0]          prod;

   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign is_tick   = (head_cmd.op == OP_TICK);
   assign pop       = (state_ff == ST_IDLE) & ~q_status.empty & (~is_tick | out_free);
   assign raw       = wave_point(wave_ff, idx_ff);
   assign prod      = raw * amp_ff;
   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign ge        = (trial >= {1'b0, div_ff});
   assign q_final   = {quo_ff[DIV_W-2:0], ge};
   assign cnt       = (q_final < DIV_W'(2)) ? DIV_W'(2) : q_final;

   always_comb begin
      f_clamped = head_cmd.data;
      if (head_cmd.data < F_MIN) begin
         f_clamped = F_MIN;
      end else if (head_cmd.data > F_MAX) begin
         f_clamped = F_MAX;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      wave_in      = wave_ff;
      amp_in       = amp_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_val_in  = pend_val_ff;
      sync_in      = sync_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      dac_in       = dac_ff;
      rv_in        = rv_ff;
      rval_in      = rval_ff;
      rsync_in     = rsync_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (head_cmd.op)
                  OP_TICK: begin
                     out_valid_in = 1'b1;
                     dac_in       = DAC_CMD | {4'd0, prod[14:7], 4'd0};
                     rv_in        = pend_ff;
                     rval_in      = pend_ff ? pend_val_ff : 32'd0;
                     rsync_in     = sync_ff;
                     pend_in      = 1'b0;
                     idx_in       = idx_ff + IDX_W'(1);
                  end
                  OP_WAVE: begin
                     wave_in = head_cmd.data[2:0];
                     idx_in  = '0;
                  end
                  OP_FREQ: begin
                     div_in   = {f_clamped[DIVISOR_W-8:0], 7'd0};
                     rem_in   = '0;
                     quo_in   = CLOCK_WORD;
                     step_in  = '0;
                     state_in = ST_DIV;
                  end
                  OP_AMP: begin
                     amp_in = head_cmd.data[7:0];
                  end
                  OP_SYNC: begin
                     sync_in = (head_cmd.data[7:0] != 8'd0);
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle, restoring
            rem_in  = ge ? DIVISOR_W'(trial - {1'b0, div_ff}) : trial[DIVISOR_W-1:0];
            quo_in  = q_final;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               pend_in     = 1'b1;
               pend_val_in = 32'd0 - cnt;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         wave_ff      <= WAVE_SIN;
         amp_ff       <= AMP_RESET;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         pend_val_ff  <= 32'd0;
         sync_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         wave_ff      <= wave_in;
         amp_ff       <= amp_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         pend_val_ff  <= pend_val_in;
         sync_ff      <= sync_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dac_ff   <= dac_in;
      rv_ff    <= rv_in;
      rval_ff  <= rval_in;
      rsync_ff <= rsync_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_dac_word     = dac_ff;
   assign rsp_reload_valid = rv_ff;
   assign rsp_reload_value = rval_ff;
   assign rsp_sync_enable  = rsync_ff;

   a_no_pop_in_div : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> !pop)
      else $error("command popped while divider busy");

   a_reload_consumed : assert property (@(posedge clock) disable iff (reset)
      (pop && head_cmd.op == OP_TICK) |=> !pend_ff)
      else $error("pending reload not cleared by tick");

endmodule

@@ rtl/framed_command_waveform_generator.sv @@
// framed command waveform generator: serial command frames in, dac words out
// instantiates fcwg_front, fcwg_queue and fcwg_back; depends on fcwg_pkg
`timescale 1ns / 1ps
// usage
// request words carry either a received serial byte (req_func low) with its
// error flag, or a sample tick (req_func high). bytes build frames of 0xff,
// command, d0..d3; a finished frame updates wave, frequency, amplitude or sync.
// each tick gives one response word: dac word, reload flag and value, sync.
// the front takes one request word per cycle while the four-entry command
// queue has room; req_stall is the queue's full flag.
// a tick passes through the command queue and the back's output register to
// rsp_valid when the back is free. a frequency command holds the back while the
// reload divider works (one quotient bit per cycle) and ticks behind it wait; its
// reload goes out with the next tick.
// while rsp_stall is high the response word holds and ticks queue up behind
// it; once the queue fills, req_stall rises.
// reset gives sine, amplitude 127, phase 0, no pending reload, sync off and an
// empty queue; no clearing pass is needed.

module framed_command_waveform_generator
   import fcwg_pkg::*;
#(
   parameter int unsigned CLOCK_HZ = 100000000
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_rx_error,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_dac_word,
   output logic        rsp_reload_valid,
   output logic [31:0] rsp_reload_value,
   output logic        rsp_sync_enable
);

   q_status_type q_status;
   logic         push;
   cmd_type      push_cmd;
   logic         pop;
   cmd_type      head_cmd;

   fcwg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_rx_byte  (req_rx_byte),
      .req_rx_error (req_rx_error),
      .q_status     (q_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   fcwg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   fcwg_back #(
      .CLOCK_HZ (CLOCK_HZ)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_cmd         (head_cmd),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dac_word     (rsp_dac_word),
      .rsp_reload_valid (rsp_reload_valid),
      .rsp_reload_value (rsp_reload_value),
      .rsp_sync_enable  (rsp_sync_enable)
   );

endmodule
